### src/cdcc_pkg.sv
// shared constants and types for the cached disc collision check
// no dependencies
package cdcc_pkg;

    localparam int ROBOT_COUNT = 64;
    localparam int ID_W        = $clog2(ROBOT_COUNT);
    localparam int SKIP_W      = 20;
    localparam int SKIP_DEPTH  = ROBOT_COUNT * ROBOT_COUNT;
    localparam int SKIP_AW     = 2 * ID_W;
    localparam longint SKIP_FULL = (64'd1 << SKIP_W) - 64'd1;
    localparam longint SKIP_CAP  = (SKIP_FULL < 64'd1000000) ? SKIP_FULL : 64'd1000000;

    localparam int POS_W  = 16;
    localparam int SPD_W  = 12;
    localparam int ROB_W  = 2 * POS_W + SPD_W;
    localparam int UNIT_W = POS_W - 4;
    localparam int NUM_W  = UNIT_W + 8;
    localparam int DEN_W  = SPD_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam int CFG_W   = 12;
    localparam int CFG_IDX = 2;

    localparam logic [CFG_IDX-1:0] CFG_ARENA_W = 2'd0;
    localparam logic [CFG_IDX-1:0] CFG_ARENA_H = 2'd1;
    localparam logic [CFG_IDX-1:0] CFG_RADIUS  = 2'd2;
    localparam logic [CFG_IDX-1:0] CFG_MARGIN  = 2'd3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALL,
        ST_SPD,
        ST_SPDW,
        ST_RD,
        ST_EVAL,
        ST_SQX,
        ST_SQY,
        ST_DIV,
        ST_CAP,
        ST_WR1,
        ST_WR2,
        ST_NEXT,
        ST_DONE
    } t_state;

endpackage

### src/cdcc_in_if.sv
// input channel of the collision check: load and check items
// depends on cdcc_pkg
interface cdcc_in_if;
    import cdcc_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [ID_W-1:0]   robot_id;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SPD_W-1:0]  speed;
    modport source (output valid, kind, robot_id, pos_x, pos_y, speed, input ready);
    modport sink   (input valid, kind, robot_id, pos_x, pos_y, speed, output ready);
endinterface

### src/cdcc_out_if.sv
// result channel of the collision check
// no dependencies
interface cdcc_out_if;
    logic valid;
    logic ready;
    logic collides;
    modport source (output valid, collides, input ready);
    modport sink   (input valid, collides, output ready);
endinterface

### src/cdcc_ram.sv
// generic single write port ram with registered read
// no dependencies
module cdcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/cached_disc_collision_check.sv
// top level of the cached disc collision check: sequencer, datapath, tables
// depends on cdcc_pkg, cdcc_in_if, cdcc_out_if, cdcc_ram
// A load item writes the robot table and gives no result. A check runs the
// wall test, fetches the mover's speed, then reads each other robot in turn:
// it moves on when skipped or not far, runs a disc test when close, writes a
// skip count directly for a zero speed sum, and else computes a new skip count
// (one quotient bit a cycle); the mover's own entry is passed over. A wall hit
// or disc hit ends it early. The robots are walked one at a time through the
// single read port of the robot table and the skip matrix. After reset a
// clearing pass zeroes the skip matrix before the first item is taken.
module cached_disc_collision_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cdcc_pkg::CFG_IDX-1:0]  i_cfg_index,
    input  logic [cdcc_pkg::CFG_W-1:0]    i_cfg_data,
    cdcc_in_if.sink                       i_in,
    cdcc_out_if.source                    o_out
);
    import cdcc_pkg::*;

    t_state r_state, n_state;

    logic [11:0] r_arena_w, r_arena_h;
    logic [7:0]  r_radius, r_margin;

    logic [ID_W-1:0]    r_id, r_i;
    logic [POS_W-1:0]   r_x, r_y;
    logic [SPD_W-1:0]   r_msp;
    logic [SKIP_AW-1:0] r_clr;
    logic [17:0]        r_rr;
    logic [UNIT_W-1:0]  r_dxu, r_dyu;
    logic [2*UNIT_W-1:0] r_sq;
    logic [NUM_W-1:0]   r_num, r_quo;
    logic [DEN_W-1:0]   r_den, r_rem;
    logic [STEP_W-1:0]  r_step;
    logic [SKIP_W-1:0]  r_cnt;
    logic               r_coll;
    logic               r_out_valid, r_out_coll;

    logic               rob_we;
    logic [ID_W-1:0]    rob_waddr, rob_raddr;
    logic [ROB_W-1:0]   rob_wdata, rob_rdata;
    logic               skip_we;
    logic [SKIP_AW-1:0] skip_waddr, skip_raddr;
    logic [SKIP_W-1:0]  skip_wdata, skip_rdata;

    cdcc_ram #(.WIDTH(ROB_W), .DEPTH(ROBOT_COUNT)) u_rob (
        .i_clk(i_clk), .i_we(rob_we), .i_waddr(rob_waddr), .i_wdata(rob_wdata),
        .i_raddr(rob_raddr), .o_rdata(rob_rdata)
    );

    cdcc_ram #(.WIDTH(SKIP_W), .DEPTH(SKIP_DEPTH)) u_skip (
        .i_clk(i_clk), .i_we(skip_we), .i_waddr(skip_waddr), .i_wdata(skip_wdata),
        .i_raddr(skip_raddr), .o_rdata(skip_rdata)
    );

    // wall test
    logic signed [17:0] xs, ys, r16, wlim, hlim;
    logic               wall;
    assign xs   = signed'({2'b00, r_x});
    assign ys   = signed'({2'b00, r_y});
    assign r16  = signed'({6'd0, r_radius, 4'd0});
    assign wlim = signed'({2'b00, r_arena_w, 4'd0}) - r16;
    assign hlim = signed'({2'b00, r_arena_h, 4'd0}) - r16;
    assign wall = (xs <= r16) || (xs >= wlim) || (ys <= r16) || (ys >= hlim);

    // per robot evaluation
    logic [POS_W-1:0]  rx, ry, adx, ady;
    logic [SPD_W-1:0]  rsp;
    logic [UNIT_W-1:0] dxu, dyu, bd;
    logic [9:0]        thresh;
    logic              in_win, far;
    logic [DEN_W-1:0]  den;
    logic [2*UNIT_W-1:0] sqy;
    logic [2*UNIT_W:0] sqsum;
    logic              disc_hit;
    logic [DEN_W:0]    trial, trial_diff;
    logic              trial_ok;

    assign rx  = rob_rdata[POS_W-1:0];
    assign ry  = rob_rdata[2*POS_W-1:POS_W];
    assign rsp = rob_rdata[ROB_W-1:2*POS_W];
    assign adx = (r_x >= rx) ? r_x - rx : rx - r_x;
    assign ady = (r_y >= ry) ? r_y - ry : ry - r_y;
    assign dxu = adx[POS_W-1:4];
    assign dyu = ady[POS_W-1:4];
    assign bd  = (dxu > dyu) ? dxu : dyu;
    assign thresh = {1'b0, r_radius, 1'b0} + {2'b00, r_margin};
    assign in_win = ({1'b0, adx} < {4'd0, r_radius, 5'd0})
                 && ({1'b0, ady} < {4'd0, r_radius, 5'd0});
    assign far = {2'b00, bd} > {4'd0, thresh};
    assign den = {1'b0, r_msp} + {1'b0, rsp};
    assign sqy = r_dyu * r_dyu;
    assign sqsum = {1'b0, r_sq} + {1'b0, sqy};
    assign disc_hit = sqsum < {7'd0, r_rr};
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign trial_diff = trial - {1'b0, r_den};
    assign trial_ok = trial >= {1'b0, r_den};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (&r_clr) n_state = ST_IDLE;
            ST_IDLE:  if (i_in.valid && i_in.kind == KIND_CHECK) n_state = ST_WALL;
            ST_WALL:  n_state = wall ? ST_DONE : ST_SPD;
            ST_SPD:   n_state = ST_SPDW;
            ST_SPDW:  n_state = ST_RD;
            ST_RD:    n_state = (r_i == r_id) ? ST_NEXT : ST_EVAL;
            ST_EVAL: begin
                if (skip_rdata != '0) n_state = ST_NEXT;
                else if (in_win)      n_state = ST_SQX;
                else if (!far)        n_state = ST_NEXT;
                else if (den == '0)   n_state = ST_WR1;
                else                  n_state = ST_DIV;
            end
            ST_SQX:   n_state = ST_SQY;
            ST_SQY:   n_state = disc_hit ? ST_DONE : ST_NEXT;
            ST_DIV:   if (r_step == STEP_W'(NUM_W - 1)) n_state = ST_CAP;
            ST_CAP:   n_state = ST_WR1;
            ST_WR1:   n_state = ST_WR2;
            ST_WR2:   n_state = ST_NEXT;
            ST_NEXT:  n_state = (&r_i) ? ST_DONE : ST_RD;
            ST_DONE:  if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory controls and handshake
    always_comb begin
        i_in.ready = 1'b0;
        rob_we     = 1'b0;
        rob_waddr  = i_in.robot_id;
        rob_wdata  = {i_in.speed, i_in.pos_y, i_in.pos_x};
        rob_raddr  = r_i;
        skip_we    = 1'b0;
        skip_waddr = {r_id, r_i};
        skip_wdata = r_cnt;
        skip_raddr = {r_id, r_i};
        unique case (r_state)
            ST_CLEAR: begin
                skip_we    = 1'b1;
                skip_waddr = r_clr;
                skip_wdata = '0;
            end
            ST_IDLE: begin
                i_in.ready = 1'b1;
                rob_we     = i_in.valid && i_in.kind == KIND_LOAD;
            end
            ST_SPD:  rob_raddr = r_id;
            ST_EVAL: begin
                skip_we    = skip_rdata != '0;
                skip_wdata = skip_rdata - SKIP_W'(1);
            end
            ST_WR1:  skip_we = 1'b1;
            ST_WR2: begin
                skip_we    = 1'b1;
                skip_waddr = {r_i, r_id};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_arena_w   <= 12'd2400;
            r_arena_h   <= 12'd2400;
            r_radius    <= 8'd16;
            r_margin    <= 8'd20;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ARENA_W: r_arena_w <= i_cfg_data;
                    CFG_ARENA_H: r_arena_h <= i_cfg_data;
                    CFG_RADIUS:  r_radius  <= i_cfg_data[7:0];
                    CFG_MARGIN:  r_margin  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_state == ST_CLEAR) r_clr <= r_clr + SKIP_AW'(1);
            if (o_out.ready) r_out_valid <= 1'b0;
            if (r_state == ST_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
                r_out_coll  <= r_coll;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                r_id   <= i_in.robot_id;
                r_x    <= i_in.pos_x;
                r_y    <= i_in.pos_y;
                r_coll <= 1'b0;
            end
            ST_WALL: begin
                r_coll <= wall;
                r_rr   <= {r_radius, 1'b0} * {r_radius, 1'b0};
            end
            ST_SPDW: begin
                r_msp <= rob_rdata[ROB_W-1:2*POS_W];
                r_i   <= '0;
            end
            ST_EVAL: begin
                r_dxu  <= dxu;
                r_dyu  <= dyu;
                r_num  <= {bd - UNIT_W'(thresh), 8'd0};
                r_den  <= den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_step <= '0;
                r_cnt  <= SKIP_W'(SKIP_CAP);
            end
            ST_SQX:  r_sq <= r_dxu * r_dxu;
            ST_SQY:  r_coll <= disc_hit;
            ST_DIV: begin
                r_rem  <= trial_ok ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_quo  <= {r_quo[NUM_W-2:0], trial_ok};
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_step <= r_step + STEP_W'(1);
            end
            ST_CAP: begin
                if (64'(r_quo) < 64'(SKIP_CAP)) r_cnt <= SKIP_W'(r_quo);
            end
            ST_NEXT: r_i <= r_i + ID_W'(1);
            default: ;
        endcase
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.collides = r_out_coll;

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_in.ready)
        else $error("item taken during clearing pass");
    a_no_skip_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !skip_we)
        else $error("skip matrix written while idle");
    a_div_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_step < STEP_W'(NUM_W)))
        else $error("divider ran past its last step");
    a_no_self_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> (r_i != r_id))
        else $error("mover tested against itself");
endmodule
